// File: rtl/gedt_pkg.sv
// Shared types and constants for the graph edge deduplication table.
package gedt_pkg;

	localparam int NODE_W    = 10;
	localparam int EDGE_W    = 12;
	localparam int MAX_NODES = 1 << NODE_W;
	localparam int MAX_EDGES = 1 << EDGE_W;
	localparam int KEY_W     = 2 * NODE_W;
	localparam int COUNT_W   = EDGE_W + 1;

	typedef enum logic [1:0] {
		ST_SELF  = 2'd0,
		ST_NEW   = 2'd1,
		ST_FOUND = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// chain link: valid flag plus edge number
	typedef struct packed {
		logic              valid;
		logic [EDGE_W-1:0] idx;
	} link_t;

	// access request from the sequencer to the edge store
	typedef struct packed {
		logic              head_we;
		logic [NODE_W-1:0] head_addr;
		link_t             head_wdata;
		logic              next_we;
		logic [EDGE_W-1:0] next_waddr;
		link_t             next_wdata;
		logic              ep_we;
		logic [EDGE_W-1:0] ep_waddr;
		logic [KEY_W-1:0]  ep_wdata;
		logic [EDGE_W-1:0] edge_raddr;
	} store_req_t;

	// registered read data back from the edge store
	typedef struct packed {
		link_t            head_rd;
		link_t            next_rd;
		logic [KEY_W-1:0] ep_rd;
	} store_rsp_t;

endpackage

// File: rtl/graph_edge_dedup_table.sv
// A self pair goes straight to the output register; any other pair reads its chain head, walks
// the chain one link per read, and ends on a match, on a full table, or on writing a new edge.
// Throughput: one item at a time; the chain walk does one memory read per cycle, so the rate
// follows the chain length of the high node.
// Reset: a clearing pass over the chain heads, input stalled; a restart item runs the same
// clearing pass before its pair is handled.
module graph_edge_dedup_table
	import gedt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              restart,
	input  logic [NODE_W-1:0] row_node,
	input  logic [NODE_W-1:0] neighbor_node,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [EDGE_W-1:0] edge_index,
	output logic [NODE_W-1:0] high_node,
	output logic [NODE_W-1:0] low_node
);

	// one-hot sequencer states
	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001, // sweep chain heads to invalid
		S_IDLE  = 8'b0000_0010, // waiting for an item
		S_HEAD  = 8'b0000_0100, // chain head read issued
		S_HCHK  = 8'b0000_1000, // head data back
		S_WALK  = 8'b0001_0000, // edge endpoints and link back
		S_WR1   = 8'b0010_0000, // write new edge, link from head if chain empty
		S_WR2   = 8'b0100_0000, // link new edge from chain tail
		S_DONE  = 8'b1000_0000  // hand result to output register
	} state_t;

	state_t             state_q, state_d;
	logic [NODE_W-1:0]  sweep_q;
	logic               pend_q;      // item waiting behind a clearing pass
	logic [COUNT_W-1:0] count_q;     // edges created since last restart
	logic [NODE_W-1:0]  hi_q, lo_q;
	logic [EDGE_W-1:0]  cur_q;       // edge under test in the walk
	logic [EDGE_W-1:0]  tail_q;      // last edge visited
	logic               have_tail_q;
	status_t            res_status_q;
	logic [EDGE_W-1:0]  res_idx_q;

	logic               out_valid_q;
	status_t            out_status_q;
	logic [EDGE_W-1:0]  out_idx_q;
	logic [NODE_W-1:0]  out_hi_q, out_lo_q;

	store_req_t         req;
	store_rsp_t         rsp;

	logic               in_take;
	logic               out_load;
	logic               in_gt;
	logic [NODE_W-1:0]  in_hi, in_lo;
	logic [KEY_W-1:0]   key;
	link_t              link_sel;
	logic               key_hit;
	logic               table_full;
	logic               sweep_last;

	gedt_store u_store (
		.clk (clk),
		.req (req),
		.rsp (rsp)
	);

	assign in_stall   = (state_q != S_IDLE);
	assign in_take    = in_valid && (state_q == S_IDLE);
	assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// order the pair
	assign in_gt      = row_node > neighbor_node;
	assign in_hi      = in_gt ? row_node : neighbor_node;
	assign in_lo      = in_gt ? neighbor_node : row_node;

	assign key        = {hi_q, lo_q};
	assign table_full = count_q[EDGE_W];
	assign sweep_last = (sweep_q == NODE_W'(MAX_NODES - 1));

	// the one compare unit: head link on the first look, chain link after that
	assign link_sel   = (state_q == S_HCHK) ? rsp.head_rd : rsp.next_rd;
	assign key_hit    = (rsp.ep_rd == key);

	// store requests
	always_comb begin
		req            = '0;
		req.head_addr  = (state_q == S_CLEAR) ? sweep_q : hi_q;
		req.head_we    = (state_q == S_CLEAR);
		req.head_wdata = '0;
		req.edge_raddr = link_sel.idx;
		req.ep_waddr   = count_q[EDGE_W-1:0];
		req.ep_wdata   = key;
		req.next_waddr = count_q[EDGE_W-1:0];
		req.next_wdata = '0;
		unique case (state_q)
			S_WR1: begin
				req.ep_we   = 1'b1;
				req.next_we = 1'b1;
				if (!have_tail_q) begin
					req.head_we    = 1'b1;
					req.head_wdata = '{valid: 1'b1, idx: count_q[EDGE_W-1:0]};
				end
			end
			S_WR2: begin
				req.next_we    = 1'b1;
				req.next_waddr = tail_q;
				req.next_wdata = '{valid: 1'b1, idx: res_idx_q};
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sweep_last) begin
					if (!pend_q) begin
						state_d = S_IDLE;
					end else if (hi_q == lo_q) begin
						state_d = S_DONE;
					end else begin
						state_d = S_HEAD;
					end
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					if (restart) begin
						state_d = S_CLEAR;
					end else if (row_node == neighbor_node) begin
						state_d = S_DONE;
					end else begin
						state_d = S_HEAD;
					end
				end
			end
			S_HEAD: state_d = S_HCHK;
			S_HCHK, S_WALK: begin
				if (state_q == S_WALK && key_hit) begin
					state_d = S_DONE;
				end else if (link_sel.valid) begin
					state_d = S_WALK;
				end else if (table_full) begin
					state_d = S_DONE;
				end else begin
					state_d = S_WR1;
				end
			end
			S_WR1: state_d = have_tail_q ? S_WR2 : S_DONE;
			S_WR2: state_d = S_DONE;
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// sequencer and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			sweep_q     <= '0;
			pend_q      <= 1'b0;
			count_q     <= '0;
			have_tail_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (in_take) begin
				sweep_q     <= '0;
				pend_q      <= restart;
				have_tail_q <= 1'b0;
				if (restart) begin
					count_q <= '0;
				end
			end
			if (state_q == S_WALK && !key_hit) begin
				have_tail_q <= 1'b1;
			end
			if (state_q == S_WR1) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// payload of the item in flight
	always_ff @(posedge clk) begin
		if (in_take) begin
			hi_q         <= in_hi;
			lo_q         <= in_lo;
			res_status_q <= ST_SELF;
			res_idx_q    <= '0;
		end
		if ((state_q == S_HCHK || state_q == S_WALK) && link_sel.valid) begin
			cur_q <= link_sel.idx;
		end
		if (state_q == S_WALK && !key_hit) begin
			tail_q <= cur_q;
		end
		if ((state_q == S_HCHK || state_q == S_WALK) && !link_sel.valid && table_full &&
				!(state_q == S_WALK && key_hit)) begin
			res_status_q <= ST_FULL;
			res_idx_q    <= '0;
		end
		if (state_q == S_WALK && key_hit) begin
			res_status_q <= ST_FOUND;
			res_idx_q    <= cur_q;
		end
		if (state_q == S_WR1) begin
			res_status_q <= ST_NEW;
			res_idx_q    <= count_q[EDGE_W-1:0];
		end
	end

	// output register: lets the next item in while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_idx_q    <= res_idx_q;
			out_hi_q     <= hi_q;
			out_lo_q     <= lo_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign edge_index = out_idx_q;
	assign high_node  = out_hi_q;
	assign low_node   = out_lo_q;

	// each new edge bumps the count by exactly one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR1) |=> (count_q == $past(count_q) + 1'b1))
		else $error("edge count did not advance on edge creation");

	// no edge is created past the table size
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR1) |-> !table_full)
		else $error("edge created in a full table");

	// skipped self pairs carry one node and index zero
	a_self_item: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_SELF) |-> (high_node == low_node && edge_index == '0))
		else $error("self pair result malformed");

	// full-table results carry index zero and a proper pair
	a_full_item: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> (edge_index == '0 && high_node > low_node))
		else $error("table full result malformed");

endmodule

// File: rtl/gedt_store.sv
// Chain head, chain link and edge endpoint memories with registered reads.
module gedt_store
	import gedt_pkg::*;
(
	input  logic       clk,
	input  store_req_t req,
	output store_rsp_t rsp
);

	link_t            head_mem [MAX_NODES];
	link_t            next_mem [MAX_EDGES];
	logic [KEY_W-1:0] ep_mem   [MAX_EDGES];

	link_t            head_rd_q;
	link_t            next_rd_q;
	logic [KEY_W-1:0] ep_rd_q;

	always_ff @(posedge clk) begin
		if (req.head_we) begin
			head_mem[req.head_addr] <= req.head_wdata;
		end
		head_rd_q <= head_mem[req.head_addr];
	end

	always_ff @(posedge clk) begin
		if (req.next_we) begin
			next_mem[req.next_waddr] <= req.next_wdata;
		end
		next_rd_q <= next_mem[req.edge_raddr];
	end

	always_ff @(posedge clk) begin
		if (req.ep_we) begin
			ep_mem[req.ep_waddr] <= req.ep_wdata;
		end
		ep_rd_q <= ep_mem[req.edge_raddr];
	end

	assign rsp.head_rd = head_rd_q;
	assign rsp.next_rd = next_rd_q;
	assign rsp.ep_rd   = ep_rd_q;

endmodule
